// ===== rtl/nsc_pkg.sv =====
package nsc_pkg;

    localparam int MAX_FIELDS_DEF = 20;
    localparam int FIELD_MASK_W   = 20;
    localparam int QUEUE_DEPTH    = 2;
    localparam int HDR_COUNT      = 8;
    localparam int HDR_MAX_LEN    = 12;
    localparam int OUT_TDATA_W    = 48;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [3:0] TYPE_UNKNOWN = 4'd0;
    localparam logic [3:0] TYPE_PLSR_1  = 4'd1;
    localparam logic [3:0] TYPE_PLSR_2  = 4'd2;
    localparam logic [3:0] TYPE_PLSR_7  = 4'd3;
    localparam logic [3:0] TYPE_GGA     = 4'd4;
    localparam logic [3:0] TYPE_GSA     = 4'd5;
    localparam logic [3:0] TYPE_GSV     = 4'd6;
    localparam logic [3:0] TYPE_HDG     = 4'd7;
    localparam logic [3:0] TYPE_RMC     = 4'd8;

    // One classified byte as it travels from the front end to the back end.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       first;
        logic       was_done;
        logic       now_done;
        logic [3:0] stype;
        logic       is_star;
        logic       is_comma;
        logic       is_space;
        logic       hex_ok;
        logic [3:0] hex_val;
    } item_t;

    typedef struct packed {
        logic                    valid_res;
        logic                    checksum_ok;
        logic [7:0]              received_sum;
        logic [7:0]              computed_sum;
        logic [4:0]              field_count;
        logic [FIELD_MASK_W-1:0] field_mask;
        logic [3:0]              sentence_type;
    } result_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    // Header text for header slot t (type t+1), padded with spaces to full length.
    function automatic logic [8*HDR_MAX_LEN-1:0] hdr_text(input logic [2:0] t);
        logic [8*HDR_MAX_LEN-1:0] txt;
        case (t)
            3'd0:    txt = "$PLSR,245,1,";
            3'd1:    txt = "$PLSR,245,2,";
            3'd2:    txt = "$PLSR,245,7,";
            3'd3:    txt = "$GPGGA,     ";
            3'd4:    txt = "$GPGSA,     ";
            3'd5:    txt = "$GPGSV,     ";
            3'd6:    txt = "$HCHDG,     ";
            3'd7:    txt = "$GPRMC,     ";
            default: txt = '0;
        endcase
        return txt;
    endfunction

    function automatic logic [3:0] hdr_len(input logic [2:0] t);
        logic [3:0] len;
        case (t)
            3'd0, 3'd1, 3'd2: len = 4'd12;
            default:          len = 4'd7;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] t, input logic [3:0] pos);
        logic [8*HDR_MAX_LEN-1:0] txt;
        logic [7:0]               c;
        txt = hdr_text(t);
        c = 8'h00;
        if (pos < 4'(HDR_MAX_LEN)) begin
            c = txt[(HDR_MAX_LEN - 1 - int'(pos)) * 8 +: 8];
        end
        return c;
    endfunction

    // Lowest surviving header wins, reported as its sentence type.
    function automatic logic [3:0] first_alive(input logic [HDR_COUNT-1:0] alive);
        logic [3:0] r;
        r = TYPE_UNKNOWN;
        for (int i = HDR_COUNT - 1; i >= 0; i--) begin
            if (alive[i]) begin
                r = 4'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] want_count(input logic [3:0] stype);
        logic [4:0] n;
        case (stype)
            TYPE_PLSR_1: n = 5'd10;
            TYPE_PLSR_2: n = 5'd10;
            TYPE_PLSR_7: n = 5'd4;
            TYPE_GGA:    n = 5'd15;
            TYPE_GSA:    n = 5'd18;
            TYPE_GSV:    n = 5'd20;
            TYPE_HDG:    n = 5'd6;
            TYPE_RMC:    n = 5'd13;
            default:     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/nsc_front.sv =====
module nsc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // ch
    input  logic                s_tlast,
    input  logic                q_ready,
    output logic                q_push,
    output nsc_pkg::item_t      q_item
);

    logic [3:0]                     pos_reg, pos_next;
    logic [nsc_pkg::HDR_COUNT-1:0]  alive_reg, alive_next;
    logic                           done_reg, done_next;
    logic [nsc_pkg::HDR_COUNT-1:0]  hit;
    logic [3:0]                     found;
    logic                           first;
    logic                           accept;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid;
    assign accept   = s_tvalid && q_ready;
    assign first    = (pos_reg == 4'd0);

    always_comb begin
        for (int t = 0; t < nsc_pkg::HDR_COUNT; t++) begin
            hit[t] = (first || alive_reg[t])
                  && (pos_reg < nsc_pkg::hdr_len(3'(t)))
                  && (nsc_pkg::hdr_char(3'(t), pos_reg) == s_tdata);
        end
        // Matching stops once a full header has been seen.
        alive_next = done_reg ? alive_reg : hit;
        found      = nsc_pkg::first_alive(alive_next);
        done_next  = done_reg;
        if (found != nsc_pkg::TYPE_UNKNOWN) begin
            if ({1'b0, pos_reg} + 5'd1 == {1'b0, nsc_pkg::hdr_len(3'(found - 4'd1))}) begin
                done_next = 1'b1;
            end
        end
        pos_next = (pos_reg == 4'd15) ? pos_reg : pos_reg + 4'd1;
    end

    always_comb begin
        q_item          = '0;
        q_item.ch       = s_tdata;
        q_item.last     = s_tlast;
        q_item.first    = first;
        q_item.was_done = done_reg;
        q_item.now_done = done_next;
        q_item.stype    = found;
        q_item.is_star  = (s_tdata == nsc_pkg::CH_STAR);
        q_item.is_comma = (s_tdata == nsc_pkg::CH_COMMA);
        q_item.is_space = (s_tdata == nsc_pkg::CH_SPACE);
        if (s_tdata inside {[8'h30:8'h39]}) begin
            q_item.hex_ok  = 1'b1;
            q_item.hex_val = s_tdata[3:0];
        end else if (s_tdata inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            q_item.hex_ok  = 1'b1;
            q_item.hex_val = s_tdata[3:0] + 4'd9;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            alive_reg <= '0;
            done_reg  <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                pos_reg   <= '0;
                alive_reg <= '0;
                done_reg  <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                alive_reg <= alive_next;
                done_reg  <= done_next;
            end
        end
    end

endmodule

// ===== rtl/nsc_queue.sv =====
module nsc_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  nsc_pkg::item_t         push_item,
    output nsc_pkg::queue_status_t status,
    input  logic                   pop,
    output nsc_pkg::item_t         head_item
);

    localparam int Depth = nsc_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    nsc_pkg::item_t  entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CntW'(Depth));
    assign push_ready   = !status.full;
    assign do_push      = push_valid && push_ready;
    assign do_pop       = pop && status.valid;
    assign head_item    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/nsc_back.sv =====
module nsc_back #(
    parameter int MAX_FIELDS = nsc_pkg::MAX_FIELDS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  nsc_pkg::item_t   q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output nsc_pkg::result_t res
);

    localparam int MaskBits = (MAX_FIELDS < nsc_pkg::FIELD_MASK_W) ?
                              MAX_FIELDS : nsc_pkg::FIELD_MASK_W;

    logic                star_reg, star1;
    logic [7:0]          xor_reg, xor1;
    logic [4:0]          idx_reg, idx1, idx2;
    logic                ne_reg, ne1;
    logic [MaskBits-1:0] mask_reg, mask1, mask2;
    logic [7:0]          hv_reg, hv1;
    logic [1:0]          hd_reg, hd1;
    logic                bad_reg, bad1;
    logic                close1;
    logic                sum_ok;
    logic [3:0]          stype;
    logic [4:0]          count;
    nsc_pkg::result_t    res_next, res_reg;
    logic                valid_reg;

    function automatic logic [MaskBits-1:0] mark(input logic [MaskBits-1:0] m,
                                                 input logic ne, input logic [4:0] idx);
        logic [MaskBits-1:0] r;
        r = m;
        if (ne && ({1'b0, idx} < 6'(MaskBits))) begin
            r = m | (MaskBits'(1) << idx);
        end
        return r;
    endfunction

    function automatic logic [4:0] sat_inc(input logic [4:0] v);
        return (v == 5'd31) ? v : v + 5'd1;
    endfunction

    // A last byte waits in the queue while the previous result is still held.
    assign q_pop = q_valid && (!q_item.last || !valid_reg || m_tready);

    always_comb begin
        star1  = star_reg;
        xor1   = xor_reg;
        idx1   = idx_reg;
        ne1    = ne_reg;
        mask1  = mask_reg;
        hv1    = hv_reg;
        hd1    = hd_reg;
        bad1   = bad_reg;
        close1 = 1'b0;

        if (!q_item.first && !star_reg && !q_item.is_star) begin
            xor1 = xor_reg ^ q_item.ch;
        end

        if (star_reg) begin
            if (!q_item.is_space) begin
                if (q_item.was_done) begin
                    ne1 = 1'b1;
                end
                if (!q_item.hex_ok || hd_reg >= 2'd2) begin
                    bad1 = 1'b1;
                end else begin
                    hv1 = {hv_reg[3:0], q_item.hex_val};
                    hd1 = hd_reg + 2'd1;
                end
            end
        end else if (q_item.is_star) begin
            star1  = 1'b1;
            close1 = q_item.was_done;
        end else if (q_item.was_done) begin
            if (q_item.is_comma) begin
                close1 = 1'b1;
            end else if (!q_item.is_space) begin
                ne1 = 1'b1;
            end
        end

        if (close1) begin
            mask1 = mark(mask_reg, ne_reg, idx_reg);
            idx1  = sat_inc(idx_reg);
            ne1   = 1'b0;
        end

        // The open field is closed when the sentence ends.
        mask2 = q_item.now_done ? mark(mask1, ne1, idx1) : mask1;
        idx2  = q_item.now_done ? sat_inc(idx1) : idx1;

        stype  = q_item.now_done ? q_item.stype : nsc_pkg::TYPE_UNKNOWN;
        count  = q_item.now_done ? idx2 : 5'd0;
        sum_ok = star1 && !bad1 && (hd1 != 2'd0) && (hv1 == xor1);

        res_next               = '0;
        res_next.sentence_type = stype;
        res_next.field_mask    = q_item.now_done ? nsc_pkg::FIELD_MASK_W'(mask2) : '0;
        res_next.field_count   = count;
        res_next.computed_sum  = xor1;
        res_next.received_sum  = hv1;
        res_next.checksum_ok   = sum_ok;
        res_next.valid_res     = (stype != nsc_pkg::TYPE_UNKNOWN)
                              && (count == nsc_pkg::want_count(stype)) && sum_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            star_reg <= 1'b0;
            xor_reg  <= '0;
            idx_reg  <= '0;
            ne_reg   <= 1'b0;
            mask_reg <= '0;
            hv_reg   <= '0;
            hd_reg   <= '0;
            bad_reg  <= 1'b0;
        end else if (q_pop) begin
            if (q_item.last) begin
                star_reg <= 1'b0;
                xor_reg  <= '0;
                idx_reg  <= '0;
                ne_reg   <= 1'b0;
                mask_reg <= '0;
                hv_reg   <= '0;
                hd_reg   <= '0;
                bad_reg  <= 1'b0;
            end else begin
                star_reg <= star1;
                xor_reg  <= xor1;
                idx_reg  <= idx1;
                ne_reg   <= ne1;
                mask_reg <= mask1;
                hv_reg   <= hv1;
                hd_reg   <= hd1;
                bad_reg  <= bad1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop && q_item.last) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.last) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign res      = res_reg;

endmodule

// ===== rtl/nmea_sentence_checker.sv =====
// NMEA 0183 sentence checker. Sentence bytes stream in on the slave side, one per
// transaction, with tlast on the final byte; each sentence yields one result
// transaction carrying the recognized type, the non-empty field mask, the field
// count and both checksums. While results are taken, the block takes one byte
// every cycle without gaps: a front end matches the header, a two-entry queue
// decouples it from the back end that splits fields and accumulates the sums,
// and the result sits in an output register, so the next sentence streams in
// while a result waits. A result is presented from that register once the back
// end pops its last byte from the queue; a stalled result holds back only the
// next last byte, and the input stalls once the queue behind that byte fills.
module nmea_sentence_checker #(
    parameter int MAX_FIELDS = nsc_pkg::MAX_FIELDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] ch
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] sentence_type, [23:4] field_mask, [28:24] field_count,
    // [36:29] computed_sum, [44:37] received_sum, [45] checksum_ok,
    // [46] valid_res, [47] zero
    output logic [nsc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic                   push_valid, push_ready;
    nsc_pkg::item_t         push_item, head_item;
    nsc_pkg::queue_status_t q_stat;
    logic                   q_pop;
    nsc_pkg::result_t       res;

    nsc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_ready  (push_ready),
        .q_push   (push_valid),
        .q_item   (push_item)
    );

    nsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .status     (q_stat),
        .pop        (q_pop),
        .head_item  (head_item)
    );

    nsc_back #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_stat.valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res      (res)
    );

    assign m_tdata = nsc_pkg::OUT_TDATA_W'(res);

    a_valid_needs_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.valid_res |->
            res.checksum_ok && res.sentence_type != nsc_pkg::TYPE_UNKNOWN)
        else $error("valid result without a matching checksum or known type");

    a_unknown_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.sentence_type == nsc_pkg::TYPE_UNKNOWN |->
            res.field_count == 5'd0 && res.field_mask == '0)
        else $error("fields reported for an unmatched header");

    a_held_item_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.valid && !q_pop |=> q_stat.valid)
        else $error("queued byte lost while the back end stalled");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(q_pop && head_item.last))
        else $error("result raised without a closing byte");

endmodule

// ===== sim/tb_nmea_sentence_checker.sv =====
module tb_nmea_sentence_checker;

    typedef logic [7:0] octet_t;

    localparam octet_t CH_DOLLAR  = 8'h24;
    localparam octet_t CH_DOT     = 8'h2E;
    localparam octet_t CH_ZERO    = 8'h30;
    localparam octet_t CH_UPPER_A = 8'h41;
    localparam octet_t CH_LOWER_A = 8'h61;
    localparam int     FIELD_LIMIT = nsc_pkg::MAX_FIELDS_DEF;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata  = 8'h00;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [nsc_pkg::OUT_TDATA_W-1:0] m_tdata;

    // Indexed by sentence type code; index 0 is the unknown type.
    string      hdr_tab [0:8] = '{"", "$PLSR,245,1,", "$PLSR,245,2,", "$PLSR,245,7,",
                                  "$GPGGA,", "$GPGSA,", "$GPGSV,", "$HCHDG,", "$GPRMC,"};
    logic [4:0] want_tab [0:8] = '{5'd0, 5'd10, 5'd10, 5'd4, 5'd15, 5'd18, 5'd20, 5'd6, 5'd13};

    // Predictor state, one sentence at a time.
    logic [3:0]                       pos_cnt;
    logic [3:0]                       cand_type;
    logic                             hdr_matched;
    logic                             star_hit;
    logic [7:0]                       run_xor;
    logic [4:0]                       fld_idx;
    logic                             fld_filled;
    logic [nsc_pkg::FIELD_MASK_W-1:0] fld_mask;
    logic [7:0]                       rx_sum;
    logic [1:0]                       rx_digits;
    logic                             rx_bad;

    nsc_pkg::result_t expected_results [$];
    nsc_pkg::result_t want_res;
    nsc_pkg::result_t got_res;
    octet_t           line_buf [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_pending   = 0;
    int mismatch_count = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;

    nmea_sentence_checker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic void clear_sentence_state();
        pos_cnt     = '0;
        cand_type   = nsc_pkg::TYPE_UNKNOWN;
        hdr_matched = 1'b0;
        star_hit    = 1'b0;
        run_xor     = '0;
        fld_idx     = '0;
        fld_filled  = 1'b0;
        fld_mask    = '0;
        rx_sum      = '0;
        rx_digits   = '0;
        rx_bad      = 1'b0;
    endfunction

    function automatic int hex_of(input octet_t c);
        if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c - CH_ZERO);
        if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return int'(c - CH_UPPER_A) + 10;
        if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return int'(c - CH_LOWER_A) + 10;
        return -1;
    endfunction

    function automatic void close_field();
        if (fld_filled && fld_idx < FIELD_LIMIT && fld_idx < nsc_pkg::FIELD_MASK_W) begin
            fld_mask[fld_idx] = 1'b1;
        end
        if (fld_idx < 5'd31) fld_idx++;
        fld_filled = 1'b0;
    endfunction

    // Narrows the header candidate: the lowest type whose header shares the
    // prefix of the current candidate and carries this byte at this position.
    function automatic void track_header(input octet_t c);
        int p;
        int base;
        int found;
        bit same;
        p = pos_cnt;
        if (p != 0 && cand_type == nsc_pkg::TYPE_UNKNOWN) return;
        base = (p == 0) ? 1 : int'(cand_type);
        if (base > 8 || p > 12) begin
            cand_type = nsc_pkg::TYPE_UNKNOWN;
            return;
        end
        found = 0;
        for (int t = base; t <= 8 && found == 0; t++) begin
            if (p < hdr_tab[t].len()) begin
                same = 1'b1;
                for (int k = 0; k < p; k++) begin
                    if (hdr_tab[t][k] != hdr_tab[base][k]) same = 1'b0;
                end
                if (same && octet_t'(hdr_tab[t][p]) == c) found = t;
            end
        end
        cand_type = 4'(found);
        if (found != 0 && p + 1 == hdr_tab[found].len()) hdr_matched = 1'b1;
    endfunction

    function automatic void predict_byte(input octet_t c, input logic is_last);
        logic             was_done;
        logic             was_star;
        int               digit;
        nsc_pkg::result_t r;
        was_done = hdr_matched;
        was_star = star_hit;
        if (pos_cnt != 0 && !was_star && c != nsc_pkg::CH_STAR) run_xor ^= c;
        if (was_star) begin
            if (c != nsc_pkg::CH_SPACE) begin
                digit = hex_of(c);
                if (was_done) fld_filled = 1'b1;
                if (digit < 0 || rx_digits >= 2) begin
                    rx_bad = 1'b1;
                end else begin
                    rx_sum = {rx_sum[3:0], 4'(digit)};
                    rx_digits++;
                end
            end
        end else if (c == nsc_pkg::CH_STAR) begin
            star_hit = 1'b1;
            if (was_done) close_field();
        end else if (was_done) begin
            if (c == nsc_pkg::CH_COMMA) close_field();
            else if (c != nsc_pkg::CH_SPACE) fld_filled = 1'b1;
        end
        if (!was_done) track_header(c);
        if (pos_cnt < 4'd15) pos_cnt++;
        if (is_last) begin
            if (hdr_matched) close_field();
            r.sentence_type = hdr_matched ? cand_type : nsc_pkg::TYPE_UNKNOWN;
            r.field_mask    = hdr_matched ? fld_mask : '0;
            r.field_count   = hdr_matched ? fld_idx : 5'd0;
            r.computed_sum  = run_xor;
            r.received_sum  = rx_sum;
            r.checksum_ok   = star_hit && !rx_bad && rx_digits >= 1 && rx_sum == run_xor;
            r.valid_res     = r.sentence_type >= nsc_pkg::TYPE_PLSR_1
                              && r.sentence_type <= nsc_pkg::TYPE_RMC
                              && r.field_count == want_tab[r.sentence_type] && r.checksum_ok;
            expected_results.push_back(r);
            clear_sentence_state();
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d, %s: expected %0h, got %0h",
                         results_seen, name, want_v, got_v);
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got_res = nsc_pkg::result_t'(m_tdata[$bits(nsc_pkg::result_t)-1:0]);
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result %0d arrived with no sentence pending: %h",
                             results_seen, m_tdata);
                end
            end else begin
                want_res = expected_results.pop_front();
                compare_field("sentence_type", want_res.sentence_type, got_res.sentence_type);
                compare_field("field_mask", want_res.field_mask, got_res.field_mask);
                compare_field("field_count", want_res.field_count, got_res.field_count);
                compare_field("computed_sum", want_res.computed_sum, got_res.computed_sum);
                compare_field("received_sum", want_res.received_sum, got_res.received_sum);
                compare_field("checksum_ok", want_res.checksum_ok, got_res.checksum_ok);
                compare_field("valid_res", want_res.valid_res, got_res.valid_res);
            end
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial begin : result_sink
        int hold_len;
        forever begin
            @(posedge aclk);
            if (hold_pending > 0) begin
                hold_len = hold_pending;
                hold_pending = 0;
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_byte(input octet_t c, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        predict_byte(c, is_last);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_byte(line_buf[i], i == line_buf.size() - 1);
        end
        line_buf.delete();
    endtask

    task automatic wait_for_results();
        int guard;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
    endtask

    function automatic void put_text(input string t);
        for (int i = 0; i < t.len(); i++) line_buf.push_back(octet_t'(t[i]));
    endfunction

    // XOR of everything after the first byte of the line built so far.
    function automatic octet_t line_checksum();
        octet_t x;
        x = '0;
        for (int i = 1; i < line_buf.size(); i++) x ^= line_buf[i];
        return x;
    endfunction

    function automatic octet_t hex_char(input logic [3:0] v, input logic lower);
        if (v < 4'd10) return CH_ZERO + octet_t'(v);
        return (lower ? CH_LOWER_A : CH_UPPER_A) + octet_t'(v) - 8'd10;
    endfunction

    function automatic void put_checksum(input logic lower);
        octet_t x;
        x = line_checksum();
        line_buf.push_back(nsc_pkg::CH_STAR);
        line_buf.push_back(hex_char(x[7:4], lower));
        line_buf.push_back(hex_char(x[3:0], lower));
    endfunction

    function automatic octet_t field_char();
        int     pick;
        octet_t c;
        pick = $urandom_range(0, 99);
        if (pick < 55) c = CH_ZERO + octet_t'($urandom_range(0, 9));
        else if (pick < 70) c = CH_UPPER_A + octet_t'($urandom_range(0, 25));
        else if (pick < 80) c = CH_DOT;
        else if (pick < 90) c = nsc_pkg::CH_SPACE;
        else begin
            c = octet_t'($urandom_range(0, 255));
            if (c == nsc_pkg::CH_STAR || c == nsc_pkg::CH_COMMA) c = CH_DOT;
        end
        return c;
    endfunction

    function automatic void put_fields(input int n);
        int len;
        for (int i = 0; i < n; i++) begin
            if (i > 0) line_buf.push_back(nsc_pkg::CH_COMMA);
            len = $urandom_range(0, 3);
            for (int k = 0; k < len; k++) line_buf.push_back(field_char());
        end
    endfunction

    function automatic void put_random_checksum();
        octet_t x;
        logic   lower;
        int     mode;
        x = line_checksum();
        lower = 1'($urandom_range(0, 1));
        mode = $urandom_range(0, 19);
        if (mode == 0) return;
        if (mode == 1) x ^= octet_t'($urandom_range(1, 255));
        line_buf.push_back(nsc_pkg::CH_STAR);
        if (mode == 2) line_buf.push_back(nsc_pkg::CH_SPACE);
        if (mode != 7) begin
            if (mode != 3) line_buf.push_back(hex_char(x[7:4], lower));
            if (mode == 8) line_buf.push_back(nsc_pkg::CH_SPACE);
            line_buf.push_back(hex_char(x[3:0], lower));
        end
        if (mode == 4) line_buf.push_back(hex_char(4'($urandom_range(0, 15)), lower));
        if (mode == 5) line_buf.push_back(octet_t'($urandom_range(0, 255)));
        if (mode == 6) begin
            line_buf.push_back(nsc_pkg::CH_SPACE);
            line_buf.push_back(nsc_pkg::CH_SPACE);
        end
    endfunction

    // Mostly well-formed sentences with random content; the rest are cut
    // short, carry a damaged header, or are plain noise.
    function automatic void build_random_sentence();
        int kind;
        int stype;
        int nfld;
        int cut;
        int len;
        kind = $urandom_range(0, 99);
        stype = $urandom_range(1, 8);
        line_buf.delete();
        if (kind < 85) begin
            nfld = want_tab[stype];
            if ($urandom_range(0, 3) == 0) nfld = $urandom_range(2, 24);
            if ($urandom_range(0, 39) == 0) nfld = $urandom_range(30, 36);
            put_text(hdr_tab[stype]);
            if (kind >= 78) begin
                line_buf[$urandom_range(0, line_buf.size() - 1)] =
                    octet_t'($urandom_range(0, 255));
            end
            put_fields(nfld - 1);
            put_random_checksum();
            if (kind >= 72 && kind < 78) begin
                cut = $urandom_range(1, line_buf.size());
                while (line_buf.size() > cut) void'(line_buf.pop_back());
            end
        end else begin
            if ($urandom_range(0, 1) == 1) line_buf.push_back(CH_DOLLAR);
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) line_buf.push_back(octet_t'($urandom_range(0, 255)));
        end
    endfunction

    task automatic test_known_headers();
        for (int t = nsc_pkg::TYPE_PLSR_1; t <= nsc_pkg::TYPE_RMC; t++) begin
            put_text(hdr_tab[t]);
            put_fields(want_tab[t] - 1);
            put_checksum(1'b0);
            send_line();
        end
        wait_for_results();
    endtask

    task automatic test_cut_and_foreign();
        // A lone dollar sign, and a lone byte with every bit set.
        line_buf.push_back(CH_DOLLAR);
        send_line();
        line_buf.push_back(8'hFF);
        send_line();
        put_text("$PLSR,24");
        send_line();
        // The first byte is never summed, so a foreign lead-in still gets a sum.
        put_text("!GPGGA,");
        put_fields(14);
        put_checksum(1'b0);
        send_line();
        put_text("$GPXXX,1,2");
        put_checksum(1'b0);
        send_line();
        wait_for_results();
    endtask

    task automatic test_checksum_text();
        octet_t x;
        put_text("$HCHDG,1,2,3,4,5");
        send_line();
        put_text("$HCHDG,a,b,c,d,e");
        put_checksum(1'b1);
        send_line();
        put_text("$HCHDG,1,2,3,4,5");
        x = line_checksum();
        line_buf.push_back(nsc_pkg::CH_STAR);
        line_buf.push_back(nsc_pkg::CH_SPACE);
        line_buf.push_back(hex_char(x[7:4], 1'b0));
        line_buf.push_back(nsc_pkg::CH_SPACE);
        line_buf.push_back(hex_char(x[3:0], 1'b0));
        line_buf.push_back(nsc_pkg::CH_SPACE);
        send_line();
        put_text("$HCHDG,1,2,3,4,5");
        put_checksum(1'b0);
        line_buf.push_back(CH_ZERO);
        send_line();
        put_text("$HCHDG,1,2,3,4,5");
        x = line_checksum();
        line_buf.push_back(nsc_pkg::CH_STAR);
        line_buf.push_back(CH_UPPER_A + 8'd6);
        line_buf.push_back(hex_char(x[3:0], 1'b0));
        send_line();
        put_text("$HCHDG,1,2,3,4,5*");
        send_line();
        put_text("$HCHDG,1,2,3,4,5");
        x = line_checksum();
        line_buf.push_back(nsc_pkg::CH_STAR);
        line_buf.push_back(nsc_pkg::CH_STAR);
        line_buf.push_back(hex_char(x[7:4], 1'b0));
        line_buf.push_back(hex_char(x[3:0], 1'b0));
        send_line();
        wait_for_results();
    endtask

    task automatic test_field_edges();
        // Far more fields than the mask holds, enough to saturate the count.
        put_text(hdr_tab[nsc_pkg::TYPE_GGA]);
        put_fields(40);
        put_checksum(1'b0);
        send_line();
        put_text(hdr_tab[nsc_pkg::TYPE_RMC]);
        for (int i = 0; i < 12; i++) begin
            if (i > 0) line_buf.push_back(nsc_pkg::CH_COMMA);
            line_buf.push_back(nsc_pkg::CH_SPACE);
        end
        put_checksum(1'b0);
        send_line();
        put_text(hdr_tab[nsc_pkg::TYPE_GSA]);
        for (int i = 0; i < 17; i++) begin
            if (i > 0) line_buf.push_back(nsc_pkg::CH_COMMA);
            line_buf.push_back((i % 2 == 0) ? 8'h00 : 8'hFF);
            if (i % 3 == 0) line_buf.push_back(8'h80);
        end
        put_checksum(1'b0);
        send_line();
        put_text(hdr_tab[nsc_pkg::TYPE_GSV]);
        put_fields(5);
        put_checksum(1'b0);
        send_line();
        put_text("$GPGGA,");
        put_checksum(1'b1);
        send_line();
        wait_for_results();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_pending = 300;
        for (int n = 0; n < 14; n++) begin
            put_text(hdr_tab[nsc_pkg::TYPE_HDG]);
            put_fields(5);
            put_checksum(1'b0);
            send_line();
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_bytes);
        int start;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            build_random_sentence();
            send_line();
        end
        wait_for_results();
    endtask

    initial begin
        clear_sentence_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_known_headers();
        test_cut_and_foreign();
        test_checksum_text();
        test_field_edges();
        test_backpressure();
        test_random_traffic(0, 0, 200);
        test_random_traffic(71, 0, 200);
        test_random_traffic(0, 71, 200);
        test_random_traffic(17, 17, 200);
        if (expected_results.size() != 0) begin
            mismatch_count += expected_results.size();
            $display("%0d sentences never produced a result", expected_results.size());
        end
        if (mismatch_count == 0) begin
            $display("tb_nmea_sentence_checker OK");
        end else begin
            $display("tb_nmea_sentence_checker NOT OK");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("run timed out");
        $display("tb_nmea_sentence_checker NOT OK");
        $finish;
    end

endmodule

// ===== nmea_sentence_checker.f =====
rtl/nsc_pkg.sv
rtl/nsc_front.sv
rtl/nsc_queue.sv
rtl/nsc_back.sv
rtl/nmea_sentence_checker.sv
sim/tb_nmea_sentence_checker.sv
